// ===== src/qau_pkg.sv =====
package qau_pkg;

    // Operation codes carried on the input tuser
    localparam int unsigned CMD_W = 2;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_MUL  = 2'd0;   // Hamilton product a*b
    localparam t_cmd CMD_ROT  = 2'd1;   // rotate vector a.xyz by quaternion b
    localparam t_cmd CMD_CONJ = 2'd2;   // conjugate of a

    // Extra integer bits kept on the rotate cross product
    localparam int unsigned CROSS_GUARD = 4;

endpackage

// ===== src/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit. Each input transfer carries a command on tuser
// (multiply, rotate vector, conjugate) and two fixed-point quaternions a and b
// on tdata; each one gives exactly one output transfer with the result and a
// saturation flag on tuser. The unit is a five-stage pipeline that takes one
// item every clock unless stalled: first pass of 16 multipliers, rounding and
// sum (or the rotate cross product c), second pass of 9 multipliers for
// rotate, rounding and v + 2t, then output saturation. Each stage holds its
// item under back-pressure and empty stages still fill, so tready falls only
// when every stage is occupied.
// Products are rounded to nearest (ties up), the rotate cross product is
// clipped to COMPONENT_BITS+4 bits, outputs clip to COMPONENT_BITS; any clip
// sets the flag. An unused command returns all zeros.
module quaternion_arithmetic_unit #(
    parameter int unsigned COMPONENT_BITS = 16,
    parameter int unsigned FRACTION_BITS  = 14
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Input stream
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // tdata: a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
    input  logic [((8*COMPONENT_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    // tuser: cmd
    input  logic [qau_pkg::CMD_W-1:0]                 i_s_axis_tuser,
    // Output stream
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    // tdata: out_x, out_y, out_z, out_w, zero pad
    output logic [((4*COMPONENT_BITS+7)/8)*8-1:0]     o_m_axis_tdata,
    // tuser: saturated
    output logic                                      o_m_axis_tuser
);

    localparam int unsigned CB     = COMPONENT_BITS;
    localparam int unsigned FB     = FRACTION_BITS;
    localparam int unsigned OUT_DW = ((4*CB+7)/8)*8;
    localparam int unsigned XW     = CB + qau_pkg::CROSS_GUARD;  // cross product width
    localparam int unsigned P1W    = 2*CB;                       // first-pass product
    localparam int unsigned SW     = 2*CB + 3;                   // first-pass sums
    localparam int unsigned P2W    = CB + XW;                    // second-pass product
    localparam int unsigned FW     = P2W + 5;                    // final wide result
    localparam int unsigned NST    = 5;

    localparam logic signed [P1W:0] HALF1 = (P1W+1)'(1) << (FB-1);
    localparam logic signed [P2W:0] HALF2 = (P2W+1)'(1) << (FB-1);

    localparam logic signed [SW-1:0] XMAX = {{(SW-XW+1){1'b0}}, {(XW-1){1'b1}}};
    localparam logic signed [SW-1:0] XMIN = ~XMAX;
    localparam logic signed [FW-1:0] OMAX = {{(FW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [FW-1:0] OMIN = ~OMAX;

    // Round a product to FB fraction bits, ties toward plus infinity
    function automatic logic signed [P1W:0] rnd1(input logic signed [P1W-1:0] p);
        logic signed [P1W:0] t;
        t = $signed({p[P1W-1], p}) + HALF1;
        return t >>> FB;
    endfunction

    function automatic logic signed [P2W:0] rnd2(input logic signed [P2W-1:0] p);
        logic signed [P2W:0] t;
        t = $signed({p[P2W-1], p}) + HALF2;
        return t >>> FB;
    endfunction

    // Clip a final value to the component range
    function automatic logic signed [CB-1:0] osat(input logic signed [FW-1:0] v);
        if (v > OMAX) begin
            return {1'b0, {(CB-1){1'b1}}};
        end else if (v < OMIN) begin
            return {1'b1, {(CB-1){1'b0}}};
        end
        return v[CB-1:0];
    endfunction

    function automatic logic oclip(input logic signed [FW-1:0] v);
        return (v > OMAX) || (v < OMIN);
    endfunction

    // ------------------------------------------------------------------
    // Pipeline handshake: a stage loads when empty or when its successor loads
    // ------------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST:0]   en;

    always_comb begin
        en[NST] = i_m_axis_tready;
        for (int k = NST-1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[NST-1];

    // ------------------------------------------------------------------
    // Stage 1: unpack and first multiplier pass
    // ------------------------------------------------------------------
    logic signed [CB-1:0] in_c [8];
    logic signed [CB-1:0] op_a [16];
    logic signed [CB-1:0] op_b [16];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            in_c[i] = $signed(i_s_axis_tdata[i*CB +: CB]);
        end
    end

    // Operand routing: index 0 ax, 1 ay, 2 az, 3 aw, 4 bx, 5 by, 6 bz, 7 bw
    always_comb begin
        // x group: aw*bx, bw*ax, ay*bz, az*by
        op_a[0]  = in_c[3]; op_b[0]  = in_c[4];
        op_a[1]  = in_c[7]; op_b[1]  = in_c[0];
        op_a[2]  = in_c[1]; op_b[2]  = in_c[6];
        op_a[3]  = in_c[2]; op_b[3]  = in_c[5];
        // y group: aw*by, bw*ay, az*bx, ax*bz
        op_a[4]  = in_c[3]; op_b[4]  = in_c[5];
        op_a[5]  = in_c[7]; op_b[5]  = in_c[1];
        op_a[6]  = in_c[2]; op_b[6]  = in_c[4];
        op_a[7]  = in_c[0]; op_b[7]  = in_c[6];
        // z group: aw*bz, bw*az, ax*by, ay*bx
        op_a[8]  = in_c[3]; op_b[8]  = in_c[6];
        op_a[9]  = in_c[7]; op_b[9]  = in_c[2];
        op_a[10] = in_c[0]; op_b[10] = in_c[5];
        op_a[11] = in_c[1]; op_b[11] = in_c[4];
        // w group: aw*bw, ax*bx, ay*by, az*bz
        op_a[12] = in_c[3]; op_b[12] = in_c[7];
        op_a[13] = in_c[0]; op_b[13] = in_c[4];
        op_a[14] = in_c[1]; op_b[14] = in_c[5];
        op_a[15] = in_c[2]; op_b[15] = in_c[6];
    end

    logic signed [P1W-1:0] p1 [16];

    for (genvar g = 0; g < 16; g++) begin : g_mul1
        qau_rmul #(
            .AW (CB),
            .BW (CB)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (en[0]),
            .i_a   (op_a[g]),
            .i_b   (op_b[g]),
            .o_p   (p1[g])
        );
    end

    logic signed [CB-1:0] r1_c [8];
    qau_pkg::t_cmd        r1_cmd;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_c   <= in_c;
            r1_cmd <= i_s_axis_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round and sum, or negate for conjugate; rotate forms c = r x v with its own clip
    // ------------------------------------------------------------------
    logic signed [SW-1:0] rq [16];
    logic signed [SW-1:0] n2_q [4];
    logic signed [XW-1:0] n2_x [3];
    logic                 n2_clip;
    logic signed [SW-1:0] cs [3];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            rq[i] = SW'(rnd1(p1[i]));
        end
        cs[0] = rq[3]  - rq[2];
        cs[1] = rq[7]  - rq[6];
        cs[2] = rq[11] - rq[10];
        n2_clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n2_x[i] = '0;
            n2_q[i] = '0;
        end
        n2_q[3] = '0;
        case (r1_cmd)
            qau_pkg::CMD_MUL: begin
                n2_q[0] = rq[0]  + rq[1]  + rq[2]  - rq[3];
                n2_q[1] = rq[4]  + rq[5]  + rq[6]  - rq[7];
                n2_q[2] = rq[8]  + rq[9]  + rq[10] - rq[11];
                n2_q[3] = rq[12] - rq[13] - rq[14] - rq[15];
            end
            qau_pkg::CMD_ROT: begin
                for (int i = 0; i < 3; i++) begin
                    if (cs[i] > XMAX) begin
                        n2_x[i] = XMAX[XW-1:0];
                        n2_clip = 1'b1;
                    end else if (cs[i] < XMIN) begin
                        n2_x[i] = XMIN[XW-1:0];
                        n2_clip = 1'b1;
                    end else begin
                        n2_x[i] = cs[i][XW-1:0];
                    end
                end
            end
            qau_pkg::CMD_CONJ: begin
                n2_q[0] = -SW'(r1_c[0]);
                n2_q[1] = -SW'(r1_c[1]);
                n2_q[2] = -SW'(r1_c[2]);
                n2_q[3] = SW'(r1_c[3]);
            end
            default: begin
                n2_clip = 1'b0;
            end
        endcase
    end

    logic signed [SW-1:0] r2_q [4];
    logic signed [XW-1:0] r2_x [3];
    logic signed [CB-1:0] r2_c [8];
    logic                 r2_clip;
    qau_pkg::t_cmd        r2_cmd;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_q    <= n2_q;
            r2_x    <= n2_x;
            r2_c    <= r1_c;
            r2_clip <= n2_clip;
            r2_cmd  <= r1_cmd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: second multiplier pass, r_w*c + r.xyz x c
    // ------------------------------------------------------------------
    logic signed [CB-1:0] op2_b [9];
    logic signed [XW-1:0] op2_x [9];

    always_comb begin
        // tx: bw*cx, by*cz, bz*cy
        op2_b[0] = r2_c[7]; op2_x[0] = r2_x[0];
        op2_b[1] = r2_c[5]; op2_x[1] = r2_x[2];
        op2_b[2] = r2_c[6]; op2_x[2] = r2_x[1];
        // ty: bw*cy, bz*cx, bx*cz
        op2_b[3] = r2_c[7]; op2_x[3] = r2_x[1];
        op2_b[4] = r2_c[6]; op2_x[4] = r2_x[0];
        op2_b[5] = r2_c[4]; op2_x[5] = r2_x[2];
        // tz: bw*cz, bx*cy, by*cx
        op2_b[6] = r2_c[7]; op2_x[6] = r2_x[2];
        op2_b[7] = r2_c[4]; op2_x[7] = r2_x[1];
        op2_b[8] = r2_c[5]; op2_x[8] = r2_x[0];
    end

    logic signed [P2W-1:0] p2 [9];

    for (genvar g = 0; g < 9; g++) begin : g_mul2
        qau_rmul #(
            .AW (CB),
            .BW (XW)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (en[2]),
            .i_a   (op2_b[g]),
            .i_b   (op2_x[g]),
            .o_p   (p2[g])
        );
    end

    logic signed [SW-1:0] r3_q [4];
    logic signed [CB-1:0] r3_v [3];
    logic                 r3_clip;
    qau_pkg::t_cmd        r3_cmd;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_q    <= r2_q;
            r3_v[0] <= r2_c[0];
            r3_v[1] <= r2_c[1];
            r3_v[2] <= r2_c[2];
            r3_clip <= r2_clip;
            r3_cmd  <= r2_cmd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round, form v + 2t for rotate, else pass the sums on
    // ------------------------------------------------------------------
    logic signed [FW-1:0] rt [9];
    logic signed [FW-1:0] n4_f [4];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            rt[i] = FW'(rnd2(p2[i]));
        end
        if (r3_cmd == qau_pkg::CMD_ROT) begin
            for (int i = 0; i < 3; i++) begin
                n4_f[i] = FW'(r3_v[i])
                        + ((rt[3*i] + rt[3*i+1] - rt[3*i+2]) <<< 1);
            end
            n4_f[3] = '0;
        end else begin
            for (int i = 0; i < 4; i++) begin
                n4_f[i] = FW'(r3_q[i]);
            end
        end
    end

    logic signed [FW-1:0] r4_f [4];
    logic                 r4_clip;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_f    <= n4_f;
            r4_clip <= r3_clip;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: output saturation and result register
    // ------------------------------------------------------------------
    logic signed [CB-1:0] r5_o [4];
    logic                 r5_clip;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int i = 0; i < 4; i++) begin
                r5_o[i] <= osat(r4_f[i]);
            end
            r5_clip <= r4_clip || oclip(r4_f[0]) || oclip(r4_f[1])
                     || oclip(r4_f[2]) || oclip(r4_f[3]);
        end
    end

    assign o_m_axis_tdata = OUT_DW'({r5_o[3], r5_o[2], r5_o[1], r5_o[0]});
    assign o_m_axis_tuser = r5_clip;

endmodule

// ===== src/qau_rmul.sv =====
// Signed multiplier with a registered product that holds while stalled
module qau_rmul #(
    parameter int unsigned AW = 16,
    parameter int unsigned BW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0] o_p
);

    logic signed [AW+BW-1:0] r_p;
    logic signed [AW+BW-1:0] n_p;

    // Full-precision product
    assign n_p = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== tb/quaternion_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_test;

    localparam int CB             = 16;
    localparam int FB             = 14;
    localparam int IN_W           = ((8*CB+7)/8)*8;
    localparam int OUT_W          = ((4*CB+7)/8)*8;
    localparam longint HALF_LSB   = longint'(1) << (FB-1);
    localparam qau_pkg::t_cmd CMD_UNUSED = 2'd3;
    localparam int RAND_PER_PHASE = 477;
    localparam int QUIET_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 20;

    typedef logic signed [CB-1:0] t_comp;

    typedef struct packed {
        qau_pkg::t_cmd cmd;
        t_comp ax, ay, az, aw;
        t_comp bx, by, bz, bw;
    } t_qop;

    typedef struct packed {
        t_comp x, y, z, w;
        logic  sat;
    } t_qres;

    // One directed row: operands, and a hand-written answer where fixed is set
    typedef struct packed {
        t_qop  op;
        logic  fixed;
        t_qres res;
    } t_row;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata  = '0;
    qau_pkg::t_cmd    s_tuser  = qau_pkg::CMD_MUL;
    logic             m_tready = 1'b0;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             o_m_axis_tuser;

    // Item currently offered on the input side
    t_qop  cur_op    = '0;
    logic  cur_fixed = 1'b0;
    t_qres cur_res   = '0;

    t_qres pending_results[$];
    t_row  dir_rows[$];
    int    src_idle_pct = 9;
    int    snk_idle_pct = 59;
    int    mismatches   = 0;
    int    n_results    = 0;
    int    n_clipped    = 0;
    int    cmd_seen[4]  = '{0, 0, 0, 0};
    int    quiet        = 0;

    quaternion_arithmetic_unit #(
        .COMPONENT_BITS(CB),
        .FRACTION_BITS (FB)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // ---------------- fixed-point quaternion predictor ----------------

    function automatic longint sx(t_comp v);
        return longint'(v);
    endfunction

    // exact product rounded to FB fraction bits, ties toward +inf
    function automatic longint rnd_mul(longint p, longint q);
        return (p * q + HALF_LSB) >>> FB;
    endfunction

    function automatic longint clip_to(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits-1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_qres quat_eval(t_qop op);
        longint a[4];
        longint b[4];
        longint r[4];
        longint c[3];
        longint raw;
        longint t;
        logic   hit;
        int     i, j, k;
        t_qres  res;
        a[0] = sx(op.ax); a[1] = sx(op.ay); a[2] = sx(op.az); a[3] = sx(op.aw);
        b[0] = sx(op.bx); b[1] = sx(op.by); b[2] = sx(op.bz); b[3] = sx(op.bw);
        hit = 1'b0;
        for (i = 0; i < 4; i++) r[i] = 0;
        case (op.cmd)
            qau_pkg::CMD_MUL: begin
                // Hamilton product; xyz rows share one cyclic pattern
                for (i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    r[i] = rnd_mul(a[3], b[i]) + rnd_mul(b[3], a[i])
                         + rnd_mul(a[j], b[k]) - rnd_mul(a[k], b[j]);
                end
                r[3] = rnd_mul(a[3], b[3]) - rnd_mul(a[0], b[0])
                     - rnd_mul(a[1], b[1]) - rnd_mul(a[2], b[2]);
            end
            qau_pkg::CMD_ROT: begin
                // c = r.xyz x v, clipped to the widened cross width
                for (i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    raw  = rnd_mul(b[j], a[k]) - rnd_mul(b[k], a[j]);
                    c[i] = clip_to(raw, CB + qau_pkg::CROSS_GUARD);
                    hit |= (c[i] != raw);
                end
                // v + 2*(w*c + r.xyz x c); a_w plays no part
                for (i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    t = rnd_mul(b[3], c[i]) + rnd_mul(b[j], c[k]) - rnd_mul(b[k], c[j]);
                    r[i] = a[i] + 2 * t;
                end
            end
            qau_pkg::CMD_CONJ: begin
                for (i = 0; i < 3; i++) r[i] = -a[i];
                r[3] = a[3];
            end
            default: begin
            end
        endcase
        for (i = 0; i < 4; i++) begin
            raw  = r[i];
            r[i] = clip_to(raw, CB);
            hit |= (r[i] != raw);
        end
        res.x   = t_comp'(r[0]);
        res.y   = t_comp'(r[1]);
        res.z   = t_comp'(r[2]);
        res.w   = t_comp'(r[3]);
        res.sat = hit;
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_row mk_row(qau_pkg::t_cmd c, int ax, int ay, int az, int aw,
                                    int bx, int by, int bz, int bw, logic fixed,
                                    int ex, int ey, int ez, int ew, logic es);
        t_row row;
        row.op.cmd = c;
        row.op.ax  = t_comp'(ax); row.op.ay = t_comp'(ay);
        row.op.az  = t_comp'(az); row.op.aw = t_comp'(aw);
        row.op.bx  = t_comp'(bx); row.op.by = t_comp'(by);
        row.op.bz  = t_comp'(bz); row.op.bw = t_comp'(bw);
        row.fixed  = fixed;
        row.res.x  = t_comp'(ex); row.res.y = t_comp'(ey);
        row.res.z  = t_comp'(ez); row.res.w = t_comp'(ew);
        row.res.sat = es;
        return row;
    endfunction

    // Mix of corner values, small values, unit-range values and full-range noise
    function automatic t_comp rand_comp();
        t_comp v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       v = t_comp'(-32768);
                    1:       v = t_comp'(32767);
                    2:       v = t_comp'(16384);
                    3:       v = t_comp'(-16384);
                    default: v = '0;
                endcase
            end
            1, 2:    v = t_comp'(int'($urandom_range(64)) - 32);
            3, 4, 5: v = t_comp'(int'($urandom_range(32768)) - 16384);
            default: v = t_comp'($urandom());
        endcase
        return v;
    endfunction

    function automatic t_qop rand_op();
        t_qop op;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 35)      op.cmd = qau_pkg::CMD_MUL;
        else if (pick < 70) op.cmd = qau_pkg::CMD_ROT;
        else if (pick < 95) op.cmd = qau_pkg::CMD_CONJ;
        else                op.cmd = CMD_UNUSED;
        op.ax = rand_comp(); op.ay = rand_comp(); op.az = rand_comp(); op.aw = rand_comp();
        op.bx = rand_comp(); op.by = rand_comp(); op.bz = rand_comp(); op.bw = rand_comp();
        return op;
    endfunction

    // Offer one item, idling at random first, and hold it until the transfer
    task automatic send_op(input t_qop op, input logic fixed, input t_qres res);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) < src_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid  <= 1'b1;
                s_tdata   <= {op.bw, op.bz, op.by, op.bx, op.aw, op.az, op.ay, op.ax};
                s_tuser   <= op.cmd;
                cur_op    <= op;
                cur_fixed <= fixed;
                cur_res   <= res;
                do @(posedge i_clk); while (!o_s_axis_tready);
                return;
            end
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ---------------- receiver back-pressure ----------------

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // ---------------- transfer monitor and scoreboard ----------------

    always @(posedge i_clk) begin
        t_qres want;
        t_qres got;
        if (i_rst_n) begin
            // input transfer: queue what this item must produce
            if (s_tvalid && o_s_axis_tready) begin
                pending_results.push_back(cur_fixed ? cur_res : quat_eval(cur_op));
                cmd_seen[cur_op.cmd]++;
            end
            // output transfer: compare with the oldest expectation
            if (o_m_axis_tvalid && m_tready) begin
                got.x   = o_m_axis_tdata[CB-1:0];
                got.y   = o_m_axis_tdata[2*CB-1:CB];
                got.z   = o_m_axis_tdata[3*CB-1:2*CB];
                got.w   = o_m_axis_tdata[4*CB-1:3*CB];
                got.sat = o_m_axis_tuser;
                n_results++;
                if (got.sat) n_clipped++;
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_x", sx(want.x), sx(got.x));
                    check_field("out_y", sx(want.y), sx(got.y));
                    check_field("out_z", sx(want.z), sx(got.z));
                    check_field("out_w", sx(want.w), sx(got.w));
                    check_field("saturated", want.sat, got.sat);
                end
            end
        end
    end

    // ---------------- watchdog on stalled traffic ----------------

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("quaternion_arithmetic_unit regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        t_row row;
        int   phase;
        int   n;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        dir_rows.push_back(mk_row(qau_pkg::CMD_MUL, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, 0, 0, 0, 0, 0));
        // multiply by the identity returns a
        dir_rows.push_back(mk_row(qau_pkg::CMD_MUL, 1000, -2000, 3000, -4000,
                                  0, 0, 0, 16384,
                                  1, 1000, -2000, 3000, -4000, 0));
        dir_rows.push_back(mk_row(qau_pkg::CMD_MUL, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768,
                                  1, 32767, 32767, 32767, -32768, 1));
        dir_rows.push_back(mk_row(qau_pkg::CMD_MUL, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767,
                                  1, 32767, 32767, 32767, -32768, 1));
        // exact half-LSB products: positive rounds up, negative rounds to zero
        dir_rows.push_back(mk_row(qau_pkg::CMD_MUL, 0, 0, 0, 1, 8192, -8192, 0, 0,
                                  1, 1, 0, 0, 0, 0));
        // i * j = k
        dir_rows.push_back(mk_row(qau_pkg::CMD_MUL, 16384, 0, 0, 0, 0, 16384, 0, 0,
                                  1, 0, 0, 16384, 0, 0));
        dir_rows.push_back(mk_row(qau_pkg::CMD_MUL, -32768, 32767, -1, 1,
                                  32767, -32768, 1, -1,
                                  0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(qau_pkg::CMD_MUL, 5000, -7000, 9000, 11000,
                                  -3000, 4000, -6000, 13000,
                                  0, 0, 0, 0, 0, 0));
        // rotate by the identity returns v, scalar input ignored
        dir_rows.push_back(mk_row(qau_pkg::CMD_ROT, 12345, -23456, 32767, -32768,
                                  0, 0, 0, 16384,
                                  1, 12345, -23456, 32767, 0, 0));
        // zero vector stays zero whatever the rotation
        dir_rows.push_back(mk_row(qau_pkg::CMD_ROT, 0, 0, 0, 32767, 32767, -32768, 12, -5,
                                  1, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(qau_pkg::CMD_ROT, 16384, 0, 0, 7, 0, 0, 11585, 11585,
                                  0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(qau_pkg::CMD_ROT, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(qau_pkg::CMD_ROT, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(qau_pkg::CMD_ROT, -32768, -32768, -32768, 0,
                                  100, -100, 50, 16000,
                                  0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(qau_pkg::CMD_ROT, 8000, -9000, 10000, 0,
                                  3000, -4000, 5000, 14000,
                                  0, 0, 0, 0, 0, 0));
        // conjugate of the most negative component clips to max positive
        dir_rows.push_back(mk_row(qau_pkg::CMD_CONJ, -32768, 5, -32768, -32768, 1, 2, 3, 4,
                                  1, 32767, -5, 32767, -32768, 1));
        dir_rows.push_back(mk_row(qau_pkg::CMD_CONJ, 32767, -32767, 0, 32767, -1, -1, -1, -1,
                                  1, -32767, 32767, 0, 32767, 0));
        dir_rows.push_back(mk_row(qau_pkg::CMD_CONJ, 1, -1, -2, -1, 0, 0, 0, 0,
                                  1, -1, 1, 2, -1, 0));
        // unused code returns all zeros
        dir_rows.push_back(mk_row(CMD_UNUSED, 32767, 32767, 32767, 32767,
                                  -32768, -32768, -32768, -32768, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_UNUSED, -1, -1, -1, -1, -1, -1, -1, -1,
                                  1, 0, 0, 0, 0, 0));

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_op(row.op, row.fixed, row.res);
        end
        drain();

        // random traffic under three stall mixes, fully drained between them
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 9;  snk_idle_pct = 59; end
                1:       begin src_idle_pct = 59; snk_idle_pct = 9;  end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            for (n = 0; n < RAND_PER_PHASE; n++) send_op(rand_op(), 1'b0, '0);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d multiply, %0d rotate, %0d conjugate, %0d unused code",
                 n_results, cmd_seen[qau_pkg::CMD_MUL], cmd_seen[qau_pkg::CMD_ROT],
                 cmd_seen[qau_pkg::CMD_CONJ], cmd_seen[CMD_UNUSED]);
        $display("%0d results clipped; stalls swept over light, heavy and no idling on both sides",
                 n_clipped);
        if (mismatches == 0) begin
            $display("quaternion_arithmetic_unit regression: pass");
        end else begin
            $display("quaternion_arithmetic_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/qau_pkg.sv
src/qau_rmul.sv
src/quaternion_arithmetic_unit.sv
tb/quaternion_arithmetic_unit_test.sv
